@@ hdl/tht_pkg.sv @@
// shared types and constants for the tcp handshake session tracker
// flag masks, connection state codes, session record and result record
// no dependencies
package tht_pkg;

    localparam logic [7:0] TCP_FIN   = 8'h01;
    localparam logic [7:0] TCP_SYN   = 8'h02;
    localparam logic [7:0] TCP_RST   = 8'h04;
    localparam logic [7:0] TCP_ACK   = 8'h10;
    localparam logic [7:0] FLAG_MASK = TCP_FIN | TCP_SYN | TCP_RST | TCP_ACK;

    localparam int STATE_W = 3;

    localparam logic [STATE_W-1:0] ST_NONE        = 3'd0;
    localparam logic [STATE_W-1:0] ST_SYN_SENT    = 3'd1;
    localparam logic [STATE_W-1:0] ST_SYNACK_SENT = 3'd2;
    localparam logic [STATE_W-1:0] ST_ESTABLISHED = 3'd3;
    localparam logic [STATE_W-1:0] ST_CLOSING     = 3'd4;
    localparam logic [STATE_W-1:0] ST_CLOSED      = 3'd5;

    localparam int SEQ_W = 32;
    localparam int LEN_W = 16;
    localparam int RTT_W = 32;

    // only the low bits of the syn time matter, the rtt is reported mod 2^32
    typedef struct packed {
        logic [STATE_W-1:0] conn_state;
        logic               client_has_base;
        logic [SEQ_W-1:0]   client_base_seq;
        logic [SEQ_W-1:0]   client_next_rel_seq;
        logic               server_has_base;
        logic [SEQ_W-1:0]   server_base_seq;
        logic [SEQ_W-1:0]   server_next_rel_seq;
        logic               first_closer_is_client;
        logic [RTT_W-1:0]   syn_time_us;
        logic [RTT_W-1:0]   measured_rtt_us;
    } tht_session_t;

    typedef struct packed {
        logic               in_sequence;
        logic [STATE_W-1:0] session_state;
        logic               became_established;
        logic               became_closed;
        logic [RTT_W-1:0]   handshake_rtt_us;
    } tht_result_t;

endpackage

@@ hdl/tcp_handshake_session_tracker.sv @@
// Tracks one TCP connection from passively observed segment headers. Each segment is
// taken into an input register, checked against the expected relative sequence of its
// side and applied to the connection state when it moves on to the result register,
// with one result per segment; a waiting result holds it in the input register. A new
// segment can be accepted every cycle while results are taken, since the state update
// that each segment feeds to the next is combinational. While a result waits, one more
// segment is held and then in_ready drops.
// Out-of-sequence segments are flagged and leave the state untouched.
// depends on tht_pkg and tht_update
module tcp_handshake_session_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         from_client,
    input  logic [7:0]                   tcp_flags,
    input  logic [tht_pkg::SEQ_W-1:0]    sequence_number,
    input  logic [tht_pkg::LEN_W-1:0]    segment_length,
    input  logic [63:0]                  timestamp_us,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         in_sequence,
    output logic [tht_pkg::STATE_W-1:0]  session_state,
    output logic                         became_established,
    output logic                         became_closed,
    output logic [tht_pkg::RTT_W-1:0]    handshake_rtt_us
);
    import tht_pkg::*;

    logic             in_valid_reg;
    logic             cli_reg;
    logic [7:0]       flags_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [LEN_W-1:0] len_reg;
    logic [RTT_W-1:0] ts_reg;

    logic             out_valid_reg;
    tht_result_t      result_reg;
    tht_session_t     sess_reg;
    tht_session_t     sess_next;
    tht_result_t      result_next;
    logic             advance;

    // the held segment moves on when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sess_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                sess_reg      <= sess_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cli_reg   <= from_client;
            flags_reg <= tcp_flags;
            seq_reg   <= sequence_number;
            len_reg   <= segment_length;
            ts_reg    <= timestamp_us[RTT_W-1:0];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    tht_update u_update (
        .sess            (sess_reg),
        .from_client     (cli_reg),
        .tcp_flags       (flags_reg),
        .sequence_number (seq_reg),
        .segment_length  (len_reg),
        .timestamp_lo    (ts_reg),
        .sess_next       (sess_next),
        .result          (result_next)
    );

    assign out_valid          = out_valid_reg;
    assign in_sequence        = result_reg.in_sequence;
    assign session_state      = result_reg.session_state;
    assign became_established = result_reg.became_established;
    assign became_closed      = result_reg.became_closed;
    assign handshake_rtt_us   = result_reg.handshake_rtt_us;

endmodule

@@ hdl/tht_update.sv @@
// per-segment session update: sequence check, handshake and fin transitions
// purely combinational, sits between the input register and the result register
// depends on tht_pkg
module tht_update (
    input  tht_pkg::tht_session_t        sess,
    input  logic                         from_client,
    input  logic [7:0]                   tcp_flags,
    input  logic [tht_pkg::SEQ_W-1:0]    sequence_number,
    input  logic [tht_pkg::LEN_W-1:0]    segment_length,
    input  logic [tht_pkg::RTT_W-1:0]    timestamp_lo,
    output tht_pkg::tht_session_t        sess_next,
    output tht_pkg::tht_result_t         result
);
    import tht_pkg::*;

    logic [7:0]       flags_m;
    logic             has_base;
    logic [SEQ_W-1:0] base_seq;
    logic [SEQ_W-1:0] cur_next;
    logic [SEQ_W-1:0] len_ext;
    logic             ok;
    logic             side_has;
    logic [SEQ_W-1:0] side_base;
    logic [SEQ_W-1:0] side_next;
    logic             estb;
    logic             closed;

    assign flags_m  = tcp_flags & FLAG_MASK;
    assign has_base = from_client ? sess.client_has_base : sess.server_has_base;
    assign base_seq = from_client ? sess.client_base_seq : sess.server_base_seq;
    assign cur_next = from_client ? sess.client_next_rel_seq : sess.server_next_rel_seq;
    assign len_ext  = {{(SEQ_W-LEN_W){1'b0}}, segment_length};

    // a side with no base yet always counts as in sequence
    assign ok = !has_base || ((sequence_number - base_seq) == cur_next);

    always_comb
    begin
        sess_next = sess;
        estb      = 1'b0;
        closed    = 1'b0;
        side_has  = has_base;
        side_base = base_seq;
        side_next = has_base ? cur_next + len_ext : cur_next;

        if (ok)
        begin
            unique case (sess.conn_state)
                ST_NONE:
                begin
                    if (flags_m == TCP_SYN && from_client)
                    begin
                        sess_next.conn_state  = ST_SYN_SENT;
                        sess_next.syn_time_us = timestamp_lo;
                        side_has  = 1'b1;
                        side_base = sequence_number;
                        side_next = SEQ_W'(1) + len_ext;
                    end
                end
                ST_SYN_SENT:
                begin
                    if (flags_m == (TCP_SYN | TCP_ACK) && !from_client)
                    begin
                        sess_next.conn_state = ST_SYNACK_SENT;
                        side_has  = 1'b1;
                        side_base = sequence_number;
                        side_next = SEQ_W'(1) + len_ext;
                    end
                end
                ST_SYNACK_SENT:
                begin
                    if (flags_m == TCP_ACK && from_client)
                    begin
                        sess_next.conn_state      = ST_ESTABLISHED;
                        sess_next.measured_rtt_us = timestamp_lo - sess.syn_time_us;
                        estb = 1'b1;
                    end
                end
                ST_ESTABLISHED:
                begin
                    if ((flags_m & TCP_FIN) != 8'h00)
                    begin
                        sess_next.conn_state             = ST_CLOSING;
                        sess_next.first_closer_is_client = from_client;
                        side_next = side_next + SEQ_W'(1);
                    end
                end
                ST_CLOSING:
                begin
                    if ((flags_m & TCP_FIN) != 8'h00 &&
                        sess.first_closer_is_client != from_client)
                    begin
                        sess_next.conn_state = ST_CLOSED;
                        side_next = side_next + SEQ_W'(1);
                        closed    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (from_client)
            begin
                sess_next.client_has_base     = side_has;
                sess_next.client_base_seq     = side_base;
                sess_next.client_next_rel_seq = side_next;
            end
            else
            begin
                sess_next.server_has_base     = side_has;
                sess_next.server_base_seq     = side_base;
                sess_next.server_next_rel_seq = side_next;
            end
        end
    end

    always_comb
    begin
        result.in_sequence        = ok;
        result.session_state      = sess_next.conn_state;
        result.became_established = estb;
        result.became_closed      = closed;
        result.handshake_rtt_us   = sess_next.measured_rtt_us;
    end

endmodule

@@ tb/sv/tcp_handshake_session_tracker_test.sv @@
// self-checking testbench for tcp_handshake_session_tracker: follows one connection
// through handshake, data, close and post-close traffic under random handshake gaps
// depends on tht_pkg and the tracker rtl
module tcp_handshake_session_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tht_pkg::*;

    localparam int RANDOM_SEGMENTS = 1800;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        logic               from_client;
        logic [7:0]         flags;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   len;
        logic [63:0]        stamp;
    } segment_t;

    typedef struct packed {
        logic [STATE_W-1:0] phase;
        logic               cli_known;
        logic [SEQ_W-1:0]   cli_base;
        logic [SEQ_W-1:0]   cli_next;
        logic               srv_known;
        logic [SEQ_W-1:0]   srv_base;
        logic [SEQ_W-1:0]   srv_next;
        logic               client_closed_first;
        logic [63:0]        syn_stamp;
        logic [RTT_W-1:0]   rtt;
    } tracker_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                from_client = 1'b0;
    logic [7:0]          tcp_flags = '0;
    logic [SEQ_W-1:0]    sequence_number = '0;
    logic [LEN_W-1:0]    segment_length = '0;
    logic [63:0]         timestamp_us = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                in_sequence;
    logic [STATE_W-1:0]  session_state;
    logic                became_established;
    logic                became_closed;
    logic [RTT_W-1:0]    handshake_rtt_us;

    segment_t    segments_to_send[$];
    tht_result_t predicted_results[$];
    tracker_t    planned = '0;   // session as the generator sees it
    tracker_t    tracked = '0;   // session as of the last accepted segment

    int in_count = 0;
    int out_count = 0;
    int seen_in = 0;
    int seen_out = 0;
    int queued_count = 0;
    int skipped_count = 0;
    int mismatches = 0;
    int quiet = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_gap = 0;
    int recv_calm = 0;
    bit hold_off = 1'b0;

    tcp_handshake_session_tracker dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .from_client        (from_client),
        .tcp_flags          (tcp_flags),
        .sequence_number    (sequence_number),
        .segment_length     (segment_length),
        .timestamp_us       (timestamp_us),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .in_sequence        (in_sequence),
        .session_state      (session_state),
        .became_established (became_established),
        .became_closed      (became_closed),
        .handshake_rtt_us   (handshake_rtt_us)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tht_result_t track_segment(input tracker_t cur, input segment_t seg,
                                                  output tracker_t nxt);
        logic [7:0]       fl;
        logic             known;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] expect_rel;
        logic             ok;
        logic             estab;
        logic             closed;
        tht_result_t      res;
        nxt = cur;
        fl = seg.flags & FLAG_MASK;
        known = seg.from_client ? cur.cli_known : cur.srv_known;
        base = seg.from_client ? cur.cli_base : cur.srv_base;
        expect_rel = seg.from_client ? cur.cli_next : cur.srv_next;
        ok = 1'b1;
        estab = 1'b0;
        closed = 1'b0;
        if (known)
        begin
            if (seg.seq - base == expect_rel)
                expect_rel = expect_rel + seg.len;
            else
                ok = 1'b0;
        end
        if (ok)
        begin
            unique case (cur.phase)
                ST_NONE:
                    if (fl == TCP_SYN && seg.from_client)
                    begin
                        nxt.phase = ST_SYN_SENT;
                        nxt.syn_stamp = seg.stamp;
                        known = 1'b1;
                        base = seg.seq;
                        expect_rel = 32'd1 + seg.len;
                    end
                ST_SYN_SENT:
                    if (fl == (TCP_SYN | TCP_ACK) && !seg.from_client)
                    begin
                        nxt.phase = ST_SYNACK_SENT;
                        known = 1'b1;
                        base = seg.seq;
                        expect_rel = 32'd1 + seg.len;
                    end
                ST_SYNACK_SENT:
                    if (fl == TCP_ACK && seg.from_client)
                    begin
                        nxt.phase = ST_ESTABLISHED;
                        nxt.rtt = seg.stamp[RTT_W-1:0] - cur.syn_stamp[RTT_W-1:0];
                        estab = 1'b1;
                    end
                ST_ESTABLISHED:
                    if ((fl & TCP_FIN) != 0)
                    begin
                        nxt.phase = ST_CLOSING;
                        nxt.client_closed_first = seg.from_client;
                        expect_rel = expect_rel + 32'd1;
                    end
                ST_CLOSING:
                    // only the side that has not closed yet can finish the close
                    if ((fl & TCP_FIN) != 0 && cur.client_closed_first != seg.from_client)
                    begin
                        nxt.phase = ST_CLOSED;
                        expect_rel = expect_rel + 32'd1;
                        closed = 1'b1;
                    end
                default: ;
            endcase
        end
        if (seg.from_client)
        begin
            nxt.cli_known = known;
            nxt.cli_base = base;
            nxt.cli_next = expect_rel;
        end
        else
        begin
            nxt.srv_known = known;
            nxt.srv_base = base;
            nxt.srv_next = expect_rel;
        end
        res = {ok, nxt.phase, estab, closed, nxt.rtt};
        return res;
    endfunction

    // absolute sequence number that the given side must use next
    function automatic logic [SEQ_W-1:0] seq_due(input logic cli);
        return cli ? planned.cli_base + planned.cli_next : planned.srv_base + planned.srv_next;
    endfunction

    task automatic queue_segment(input logic cli, input logic [7:0] flags,
                                 input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                                 input logic [63:0] stamp);
        segment_t seg;
        tracker_t nxt;
        seg = {cli, flags, seq, len, stamp};
        void'(track_segment(planned, seg, nxt));
        planned = nxt;
        segments_to_send.push_back(seg);
        queued_count++;
    endtask

    // mostly short gaps, some long ones, and now and then a calm stretch with none
    task automatic draw_gap(inout int calm, output int gap);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else if (roll == 0)
        begin
            calm = $urandom_range(40, 200);
            gap = 0;
        end
        else if (roll < 55)
            gap = 0;
        else if (roll < 88)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 15);
        else
            gap = $urandom_range(30, 80);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %s is %0h, expected %0h", out_count, what, got, want);
        mismatches++;
    endtask

    always @(negedge clk)
    begin : sender
        segment_t seg;
        bit       free;
        free = !in_valid || (in_count != seen_in);
        seen_in = in_count;
        if (free)
        begin
            if (rst_n && send_gap == 0 && segments_to_send.size() > 0)
            begin
                seg = segments_to_send.pop_front();
                from_client <= seg.from_client;
                tcp_flags <= seg.flags;
                sequence_number <= seg.seq;
                segment_length <= seg.len;
                timestamp_us <= seg.stamp;
                in_valid <= 1'b1;
                draw_gap(send_calm, send_gap);
            end
            else
            begin
                in_valid <= 1'b0;
                if (rst_n && send_gap > 0)
                    send_gap--;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (out_count != seen_out)
        begin
            seen_out = out_count;
            draw_gap(recv_calm, recv_gap);
        end
        if (hold_off)
            out_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap--;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        tht_result_t want;
        tht_result_t got;
        tracker_t    after;
        if (rst_n)
        begin
            quiet++;
            if (in_valid && in_ready)
            begin
                want = track_segment(tracked,
                    {from_client, tcp_flags, sequence_number, segment_length, timestamp_us},
                    after);
                tracked = after;
                predicted_results.push_back(want);
                in_count++;
                quiet = 0;
            end
            if (out_valid && out_ready)
            begin
                out_count++;
                quiet = 0;
                got = {in_sequence, session_state, became_established, became_closed,
                       handshake_rtt_us};
                if (predicted_results.size() == 0)
                    report_mismatch("result with no transaction pending", 64'(got), '0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (!want.in_sequence)
                        skipped_count++;
                    if (got.in_sequence !== want.in_sequence)
                        report_mismatch("in_sequence", 64'(got.in_sequence),
                                        64'(want.in_sequence));
                    if (got.session_state !== want.session_state)
                        report_mismatch("session_state", 64'(got.session_state),
                                        64'(want.session_state));
                    if (got.became_established !== want.became_established)
                        report_mismatch("became_established", 64'(got.became_established),
                                        64'(want.became_established));
                    if (got.became_closed !== want.became_closed)
                        report_mismatch("became_closed", 64'(got.became_closed),
                                        64'(want.became_closed));
                    if (got.handshake_rtt_us !== want.handshake_rtt_us)
                        report_mismatch("handshake_rtt_us", 64'(got.handshake_rtt_us),
                                        64'(want.handshake_rtt_us));
                end
            end
        end
    end

    // long receiver stall halfway through so the pipeline fills and in_ready drops
    initial
    begin : backpressure
        wait (in_count >= 900);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : watchdog
        wait (quiet >= STALL_LIMIT);
        $display("no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, predicted_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int               i;
        logic             cli;
        logic [7:0]       flags;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        int               roll;
        bit               fin_ok;

        // before any handshake: extremes, and flag sets that must not start one
        queue_segment(1'b0, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_segment(1'b1, TCP_SYN | TCP_RST, 32'h0, 16'h0, 64'h0);
        queue_segment(1'b0, TCP_SYN, 32'h1111_0000, 16'd20, 64'd100);
        queue_segment(1'b1, TCP_SYN | TCP_ACK, 32'h2222_0000, 16'd0, 64'd200);
        // syn with unmasked high flag bits, base near the top so next wraps
        queue_segment(1'b1, TCP_SYN | 8'hE0, 32'hFFFF_FFF0, 16'hFFFF,
                      64'hFFFF_FFFF_0000_1000);
        queue_segment(1'b1, TCP_ACK, 32'h0000_1234, 16'd1, 64'd300);
        queue_segment(1'b0, TCP_SYN, 32'h3333_0000, 16'd0, 64'd400);
        queue_segment(1'b1, TCP_ACK, seq_due(1'b1), 16'd5, 64'd500);
        queue_segment(1'b0, TCP_SYN | TCP_ACK | TCP_RST, 32'h8000_0000, 16'd0, 64'd600);
        queue_segment(1'b0, TCP_SYN | TCP_ACK | 8'hC8, 32'h8000_0000, 16'd0, 64'h2000);
        queue_segment(1'b0, TCP_ACK, 32'h8000_0000, 16'd0, 64'd700);
        queue_segment(1'b1, TCP_ACK | TCP_FIN, seq_due(1'b1), 16'd0, 64'd800);
        // final ack stamped earlier than the syn in the low 32 bits
        queue_segment(1'b1, TCP_ACK | 8'h08, seq_due(1'b1), 16'd100,
                      64'h0000_0001_0000_0800);
        queue_segment(1'b0, TCP_ACK, seq_due(1'b0), 16'hFFFF, 64'h0);
        queue_segment(1'b1, TCP_FIN | TCP_ACK, seq_due(1'b1) + 32'd7, 16'd3, 64'd900);
        queue_segment(1'b0, TCP_RST, seq_due(1'b0), 16'd0, 64'd1000);
        queue_segment(1'b1, 8'hFE, seq_due(1'b1), 16'd0, 64'h0);
        queue_segment(1'b0, 8'h00, seq_due(1'b0), 16'd1460, 64'd1100);

        // data in order with random content, some noise; fins allowed later on
        for (i = 0; i < RANDOM_SEGMENTS; i++)
        begin
            cli = 1'($urandom_range(0, 1));
            flags = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 19);
            if (roll == 0)
                len = 16'h0;
            else if (roll == 1)
                len = 16'hFFFF;
            else if (roll == 2)
                len = LEN_W'($urandom_range(0, 65535));
            else
                len = LEN_W'($urandom_range(0, 1460));
            if ($urandom_range(0, 99) < 15)
            begin
                if ($urandom_range(0, 1))
                    seq = $urandom;
                else
                    seq = seq_due(cli) + $urandom_range(1, 1000);
            end
            else
            begin
                fin_ok = (planned.phase == ST_ESTABLISHED && i >= 600) ||
                         (planned.phase == ST_CLOSING && i >= 1200) ||
                         planned.phase == ST_CLOSED;
                if (!fin_ok || $urandom_range(0, 9) != 0)
                    flags = flags & ~TCP_FIN;
                seq = seq_due(cli);
            end
            queue_segment(cli, flags, seq, len, {$urandom, $urandom});
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (in_count < queued_count)
            @(posedge clk);
        while (predicted_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d segments through handshake, data, close and after close; %0d out of seq",
                 in_count, skipped_count);
        $display("final state %0d, rtt %0d us, %0d results compared, held off %0d cycles",
                 tracked.phase, tracked.rtt, out_count, HOLD_CYCLES);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tht_pkg.sv
hdl/tht_update.sv
hdl/tcp_handshake_session_tracker.sv
tb/sv/tcp_handshake_session_tracker_test.sv
